// ----- rtl/core/dtli_pkg.sv -----
// ----------------------------------------------------------------------------
// dtli_pkg: shared types and constants of the daily table interpolator
// Field widths, command and status codes, and the queue word that passes
// from the front classifier to the back table and interpolation pipe.
// ----------------------------------------------------------------------------
package dtli_pkg;

	// fixed field widths
	localparam int DAY_W   = 20;
	localparam int FRAC_W  = 32;
	localparam int VAL_W   = 32;
	localparam int NVAL    = 6;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 3;

	// stream payload: day, frac, six values, zero padded to whole bytes
	localparam int PAYLOAD_W = DAY_W + FRAC_W + NVAL * VAL_W;
	localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
	localparam int PAD_W     = TDATA_W - PAYLOAD_W;

	// widest table address over the allowed depth range
	localparam int ADDR_MAX_W = 16;

	// front to back queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_BEFORE = 3'd2;
	localparam logic [STAT_W-1:0] STAT_AFTER  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL   = 3'd4;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef val_t [NVAL-1:0] row_t;

	// what the back does with a word
	typedef enum logic [1:0] {
		OP_ZERO,
		OP_APPEND,
		OP_QUERY
	} op_t;

	// classified command, front to back
	typedef struct packed {
		op_t                   op;
		logic [STAT_W-1:0]     status;
		logic [DAY_W-1:0]      day;
		logic [FRAC_W-1:0]     frac;
		logic [ADDR_MAX_W-1:0] addr;
		row_t                  vals;
	} entry_t;

	// finished result word
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DAY_W-1:0]  day;
		logic [FRAC_W-1:0] frac;
		row_t              vals;
	} result_t;

endpackage

// ----- rtl/core/dtli_queue.sv -----
// ----------------------------------------------------------------------------
// dtli_queue: short queue between front and back
// Small register FIFO of classified command words; push and pop may happen
// in the same cycle.
// ----------------------------------------------------------------------------
module dtli_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dtli_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output dtli_pkg::entry_t head
);

	dtli_pkg::entry_t                 slots_q [dtli_pkg::QDEPTH];
	logic [dtli_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [dtli_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [dtli_pkg::QPTR_W:0]        count_q;

	assign full  = (count_q == (dtli_pkg::QPTR_W+1)'(dtli_pkg::QDEPTH));
	assign valid = (count_q != '0);
	assign head  = slots_q[rd_ptr_q];

	// storage, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/dtli_front.sv -----
// ----------------------------------------------------------------------------
// dtli_front: command classifier
// Tracks the row count, decides the status of each command and pushes one
// classified word per accepted input word into the queue.
// ----------------------------------------------------------------------------
module dtli_front #(
	parameter int TABLE_DEPTH = 4096,
	parameter int FRAC_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dtli_pkg::CMD_W-1:0]    cmd,
	input  logic [dtli_pkg::DAY_W-1:0]    day,
	input  logic [dtli_pkg::FRAC_W-1:0]   frac,
	input  dtli_pkg::row_t                vals,
	input  logic [dtli_pkg::DAY_W-1:0]    base_day,
	input  logic                          q_full,
	output logic                          q_push,
	output dtli_pkg::entry_t              q_entry
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int OW = ((CW > dtli_pkg::DAY_W) ? CW : dtli_pkg::DAY_W) + 1;
	localparam logic [dtli_pkg::FRAC_W-1:0] FMASK =
		dtli_pkg::FRAC_W'((64'd1 << FRAC_BITS) - 64'd1);

	logic [CW-1:0]                 row_count_q;
	logic [dtli_pkg::FRAC_W-1:0]   frac_m;
	logic [dtli_pkg::DAY_W-1:0]    offset;
	logic [dtli_pkg::DAY_W-1:0]    app_day;
	logic [OW-1:0]                 off_x;
	logic [OW-1:0]                 cnt_x;
	logic                          too_early;
	logic                          past;
	logic                          tbl_full;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// range checks against the current table
	assign frac_m    = frac & FMASK;
	assign offset    = day - base_day;
	assign app_day   = base_day + dtli_pkg::DAY_W'(row_count_q);
	assign off_x     = OW'(offset);
	assign cnt_x     = OW'(row_count_q);
	assign too_early = (day < base_day);
	assign past      = (off_x >= cnt_x) ||
	                   ((OW'(off_x + OW'(1)) == cnt_x) && (frac_m != '0));
	assign tbl_full  = (row_count_q == CW'(TABLE_DEPTH));

	// classify
	always_comb begin
		q_entry        = '0;
		q_entry.op     = dtli_pkg::OP_ZERO;
		q_entry.status = dtli_pkg::STAT_OK;
		unique case (cmd)
			dtli_pkg::CMD_CLEAR: begin
				q_entry.op = dtli_pkg::OP_ZERO;
			end
			dtli_pkg::CMD_APPEND: begin
				if (tbl_full) begin
					q_entry.status = dtli_pkg::STAT_FULL;
				end else begin
					q_entry.op   = dtli_pkg::OP_APPEND;
					q_entry.day  = app_day;
					q_entry.addr = dtli_pkg::ADDR_MAX_W'(row_count_q[AW-1:0]);
					q_entry.vals = vals;
				end
			end
			dtli_pkg::CMD_QUERY: begin
				if (row_count_q == '0) begin
					q_entry.status = dtli_pkg::STAT_EMPTY;
				end else if (too_early) begin
					q_entry.status = dtli_pkg::STAT_BEFORE;
				end else if (past) begin
					q_entry.status = dtli_pkg::STAT_AFTER;
				end else begin
					q_entry.op   = dtli_pkg::OP_QUERY;
					q_entry.day  = day;
					q_entry.frac = frac_m;
					q_entry.addr = dtli_pkg::ADDR_MAX_W'(offset[AW-1:0]);
				end
			end
			default: begin
				q_entry.op = dtli_pkg::OP_ZERO;
			end
		endcase
	end

	// row count follows accepted clears and appends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
		end else if (q_push) begin
			if (cmd == dtli_pkg::CMD_CLEAR) begin
				row_count_q <= '0;
			end else if (cmd == dtli_pkg::CMD_APPEND && !tbl_full) begin
				row_count_q <= row_count_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/dtli_back.sv -----
// ----------------------------------------------------------------------------
// dtli_back: table store and interpolation pipe
// Writes appended rows, reads two adjacent rows per query and runs six
// lanes of diff, multiply and add into the output register.
// ----------------------------------------------------------------------------
module dtli_back #(
	parameter int TABLE_DEPTH = 4096,
	parameter int FRAC_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  dtli_pkg::entry_t  q_head,
	output logic              q_pop,
	output logic              m_valid,
	input  logic              m_ready,
	output dtli_pkg::result_t m_res
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int FB = FRAC_BITS;

	dtli_pkg::row_t          table_q [TABLE_DEPTH];
	logic [AW-1:0]           ra;
	logic [AW-1:0]           rb;
	logic                    adv;

	logic                    valid_s1, valid_s2, valid_s3;
	dtli_pkg::entry_t        entry_s1, entry_s2, entry_s3;
	dtli_pkg::row_t          rd_a_s1, rd_b_s1;
	dtli_pkg::row_t          a_s2, a_s3;
	logic signed [32:0]      d_s2 [dtli_pkg::NVAL];
	logic signed [FB+33:0]   p_s3 [dtli_pkg::NVAL];
	logic                    lerp_en;
	dtli_pkg::row_t          sum;

	logic                    out_valid_q;
	dtli_pkg::result_t       out_q;

	// whole pipe moves when the output register is free or being taken
	assign adv     = !out_valid_q || m_ready;
	assign q_pop   = adv && q_valid;
	assign ra      = q_head.addr[AW-1:0];
	assign rb      = ra + 1'b1;
	assign m_valid = out_valid_q;
	assign m_res   = out_q;

	// table: append writes one row, query reads rows i and i+1
	always_ff @(posedge clk) begin
		if (q_pop && q_head.op == dtli_pkg::OP_APPEND) begin
			table_q[ra] <= q_head.vals;
		end
		if (q_pop && q_head.op == dtli_pkg::OP_QUERY) begin
			rd_a_s1 <= table_q[ra];
			rd_b_s1 <= table_q[rb];
		end
	end

	// next row only matters for a query with a nonzero fraction
	assign lerp_en = (entry_s1.op == dtli_pkg::OP_QUERY) && (entry_s1.frac != '0);

	// pipe payload
	always_ff @(posedge clk) begin
		if (adv) begin
			entry_s1 <= q_head;
			entry_s2 <= entry_s1;
			entry_s3 <= entry_s2;
			a_s2     <= rd_a_s1;
			a_s3     <= a_s2;
			for (int k = 0; k < dtli_pkg::NVAL; k++) begin
				d_s2[k] <= lerp_en ?
					(33'(rd_b_s1[k]) - 33'(rd_a_s1[k])) : 33'sd0;
				p_s3[k] <= $signed({1'b0, entry_s2.frac[FB-1:0]}) * d_s2[k];
			end
		end
	end

	// value plus floor of frac times diff
	always_comb begin
		for (int k = 0; k < dtli_pkg::NVAL; k++) begin
			sum[k] = dtli_pkg::VAL_W'(34'(a_s3[k]) + $signed(p_s3[k][FB+33:FB]));
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			out_q.status <= entry_s3.status;
			out_q.day    <= entry_s3.day;
			out_q.frac   <= entry_s3.frac;
			out_q.vals   <= (entry_s3.op == dtli_pkg::OP_QUERY) ? sum : entry_s3.vals;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

endmodule

// ----- rtl/core/daily_table_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// daily_table_linear_interpolator: day table with linear interpolation
// Path: queue register, pipe stages s1 to s3, output register. Throughput:
// one word per cycle unless m_tready stalls the output, set by the single
// back pipe and the two-read table memory; the front stalls only when the
// 4-word queue fills. Reset clears base_day, row count, queue and pipe valid bits
// at once; the table contents are undefined until appended, with no clearing pass.
// ----------------------------------------------------------------------------
module daily_table_linear_interpolator #(
	parameter int TABLE_DEPTH = 4096,
	parameter int FRAC_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration: base_day
	input  logic                              cfg_we,
	input  logic [dtli_pkg::DAY_W-1:0]        cfg_wdata,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cmd
	input  logic [dtli_pkg::CMD_W-1:0]        s_tuser,
	// day, frac, x_pole, y_pole, ut1_minus_utc, length_of_day, nut_dx, nut_dy
	input  logic [dtli_pkg::TDATA_W-1:0]      s_tdata,
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status
	output logic [dtli_pkg::STAT_W-1:0]       m_tuser,
	// day_out, frac_out, out_x_pole, out_y_pole, out_ut1_minus_utc,
	// out_length_of_day, out_nut_dx, out_nut_dy
	output logic [dtli_pkg::TDATA_W-1:0]      m_tdata
);

	localparam int FRAC_LO = dtli_pkg::DAY_W;
	localparam int VALS_LO = dtli_pkg::DAY_W + dtli_pkg::FRAC_W;

	logic [dtli_pkg::DAY_W-1:0] base_day_q;
	logic                       q_full;
	logic                       q_push;
	logic                       q_valid;
	logic                       q_pop;
	dtli_pkg::entry_t           q_entry;
	dtli_pkg::entry_t           q_head;
	dtli_pkg::result_t          res;

	// base day register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_day_q <= '0;
		end else if (cfg_we) begin
			base_day_q <= cfg_wdata;
		end
	end

	dtli_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (s_tuser),
		.day      (s_tdata[dtli_pkg::DAY_W-1:0]),
		.frac     (s_tdata[FRAC_LO +: dtli_pkg::FRAC_W]),
		.vals     (dtli_pkg::row_t'(s_tdata[VALS_LO +: dtli_pkg::NVAL*dtli_pkg::VAL_W])),
		.base_day (base_day_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	dtli_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (q_head)
	);

	dtli_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_res   (res)
	);

	// pack result word
	assign m_tuser = res.status;
	assign m_tdata = {{dtli_pkg::PAD_W{1'b0}}, res.vals, res.frac, res.day};

	// error results carry an all-zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != dtli_pkg::STAT_OK) |-> (m_tdata == '0))
		else $error("error result with nonzero payload");

	// returned fraction never uses bits above FRAC_BITS
	a_frac_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((64'(m_tdata[FRAC_LO +: dtli_pkg::FRAC_W]) >> FRAC_BITS) == 64'd0))
		else $error("frac_out wider than FRAC_BITS");

endmodule
